FILE: design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous active-low reset masking.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
  `ASSERT_AT(lbl, clk, rst_n, (pre) |-> (post), msg)

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  `ASSERT_AT(lbl, clk, rst_n, (pre) |=> (post), msg)

`endif

FILE: design/pdt_pkg.sv
// Types and constants of the PD torque block.
package pdt_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_POS_GAIN      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_VEL_GAIN      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TORQUE_LIMIT  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PD_ENABLE     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_STEP_LIMIT_ON = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_STEP_LIMIT    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_FILTER_ALPHA  = 3'd6;

  localparam logic [14:0] TORQUE_LIMIT_RST = 15'd25600;
  localparam logic [14:0] STEP_LIMIT_RST   = 15'd32767;
  localparam logic [15:0] FILTER_ALPHA_RST = 16'hFFFF;

  typedef struct packed {
    logic signed [15:0] target_pos;
    logic signed [15:0] measured_pos;
    logic signed [15:0] target_vel;
    logic signed [15:0] measured_vel;
    logic signed [15:0] feedforward_torque;
  } in_t;

  typedef struct packed {
    logic signed [15:0] drive_torque;
    logic               clamped;
  } out_t;

  typedef struct packed {
    logic [15:0] pos_gain;
    logic [15:0] vel_gain;
    logic [14:0] torque_limit;
    logic        pd_enable;
    logic        step_limit_on;
    logic [14:0] step_limit;
    logic [15:0] filter_alpha;
  } cfg_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_in;
    logic mul_pos;
    logic mul_vel;
    logic form_x;
    logic mul_filt;
    logic upd_filt;
    logic load_out;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_blocked;
  } sts_t;

endpackage

FILE: design/pdt_ctrl.sv
// Sequencer for the input load, the shared multiplier, the filter update and the output register.
module pdt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pdt_pkg::sts_t sts_i,
  output pdt_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POS  = 3'd1;
  localparam logic [2:0] S_VEL  = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_FILT = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_POS;
        end
      end
      S_POS: begin
        cmd_o.mul_pos = 1'b1;
        state_d       = S_VEL;
      end
      S_VEL: begin
        cmd_o.mul_vel = 1'b1;
        state_d       = S_SUM;
      end
      S_SUM: begin
        cmd_o.form_x = 1'b1;
        state_d      = S_FILT;
      end
      S_FILT: begin
        cmd_o.mul_filt = 1'b1;
        state_d        = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd_filt = 1'b1;
        state_d        = S_OUT;
      end
      S_OUT: begin
        // hold until the previous word has left the output register
        if (!sts_i.out_blocked) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: design/pdt_dp.sv
// Datapath: step limit, shared multiplier, low-pass filter, output clamp.
module pdt_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pdt_pkg::cfg_t cfg_i,
  input  pdt_pkg::cmd_t cmd_i,
  output pdt_pkg::sts_t sts_o,
  input  pdt_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pdt_pkg::out_t out_data_o
);

  // state
  logic signed [31:0] y_q, y_d;
  logic signed [15:0] last_q;

  // per-word payload
  logic signed [15:0] cmd_pos_q;
  logic signed [15:0] mpos_q;
  logic signed [16:0] verr_q;
  logic signed [15:0] ff_q;
  logic signed [49:0] prod_q;
  logic signed [33:0] pt_q;
  logic signed [31:0] x_q;
  logic               out_valid_q;
  pdt_pkg::out_t      out_q;

  // commanded position
  logic signed [16:0] delta, delta_sel, lim17, cmd17;
  logic        [16:0] delta_mag;

  always_comb begin
    lim17     = signed'({2'b00, cfg_i.step_limit});
    delta     = 17'(in_data_i.target_pos) - 17'(last_q);
    delta_mag = delta[16] ? 17'(-delta) : 17'(delta);
    delta_sel = delta;
    if (cfg_i.step_limit_on && (delta_mag >= 17'(lim17))) begin
      delta_sel = delta[16] ? -lim17 : lim17;
    end
    cmd17 = (cfg_i.step_limit_on ? 17'(last_q) + delta_sel : 17'(in_data_i.target_pos));
  end

  // shared multiplier
  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] prod;

  always_comb begin
    if (cmd_i.mul_pos) begin
      mul_a = 33'(17'(cmd_pos_q) - 17'(mpos_q));
      mul_b = signed'({1'b0, cfg_i.pos_gain});
    end else if (cmd_i.mul_vel) begin
      mul_a = 33'(verr_q);
      mul_b = signed'({1'b0, cfg_i.vel_gain});
    end else begin
      mul_a = 33'(x_q) - 33'(y_q);
      mul_b = signed'({1'b0, cfg_i.filter_alpha});
    end
    prod = 50'(mul_a) * 50'(mul_b);
  end

  // PD sum and filter input, floor of sum / 2^14
  logic signed [38:0] pd_sum;
  assign pd_sum = 39'(pt_q) + signed'({prod_q[34:0], 4'b0000});

  // filter increment, rounded half up
  logic signed [49:0] rnd;
  assign rnd = prod_q + 50'sd32768;
  assign y_d = y_q + 32'(rnd[49:16]);

  // feedforward and clamp
  logic signed [32:0] tsum;
  logic        [32:0] tmag, tlim;
  logic signed [15:0] lim16;
  logic               clip;

  always_comb begin
    tsum  = 33'(y_q) + 33'(ff_q);
    tmag  = tsum[32] ? 33'(-tsum) : 33'(tsum);
    tlim  = {18'd0, cfg_i.torque_limit};
    lim16 = signed'({1'b0, cfg_i.torque_limit});
    clip  = (tmag >= tlim);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_pos_q <= cmd17[15:0];
      mpos_q    <= in_data_i.measured_pos;
      verr_q    <= 17'(in_data_i.target_vel) - 17'(in_data_i.measured_vel);
      ff_q      <= in_data_i.feedforward_torque;
    end
    if (cmd_i.mul_pos || cmd_i.mul_vel || cmd_i.mul_filt) begin
      prod_q <= prod;
    end
    if (cmd_i.mul_vel) begin
      pt_q <= prod_q[33:0];
    end
    if (cmd_i.form_x) begin
      x_q <= cfg_i.pd_enable ? 32'(signed'(pd_sum[38:14])) : 32'sd0;
    end
    if (cmd_i.load_out) begin
      out_q.clamped      <= clip;
      out_q.drive_torque <= clip ? (tsum[32] ? -lim16 : lim16) : tsum[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_q         <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_in) begin
        last_q <= cmd17[15:0];
      end
      if (cmd_i.upd_filt) begin
        y_q <= y_d;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_blocked = out_valid_q && out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

FILE: design/pd_torque_with_filter_and_limits.sv
// PD torque step with feedforward, output filter and limits: top level.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one word per control
// step with target and measured position and velocity plus feedforward.
// Output channel (out_valid_o / out_stall_i / out_data_o): one word per input
// word, the clamped drive torque and a flag set when the limit was reached.
// Configuration: cfg_we_i writes cfg_wdata_i into the register at cfg_idx_i;
// write only while no word is in flight. Indexes beyond the list are ignored.
// Steps in turn: input register on acceptance, position product, velocity
// product, PD sum, filter product, filter update, output load. The gain and
// filter products all go through one shared multiplier, and in_stall_o
// stays high until the result enters the output register.
// Reset clears the filter level and last commanded position to zero and
// loads the register defaults. When the receiver stalls, the result waits in
// the output register; a new word can be accepted and worked on meanwhile,
// and it holds in its last step until that register is free.
`include "assert_macros.svh"

module pd_torque_with_filter_and_limits (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pdt_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pdt_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  pdt_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output pdt_pkg::out_t                  out_data_o
);

  pdt_pkg::cfg_t cfg_q;
  pdt_pkg::cmd_t cmd;
  pdt_pkg::sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_gain      <= '0;
      cfg_q.vel_gain      <= '0;
      cfg_q.torque_limit  <= pdt_pkg::TORQUE_LIMIT_RST;
      cfg_q.pd_enable     <= 1'b1;
      cfg_q.step_limit_on <= 1'b0;
      cfg_q.step_limit    <= pdt_pkg::STEP_LIMIT_RST;
      cfg_q.filter_alpha  <= pdt_pkg::FILTER_ALPHA_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pdt_pkg::REG_POS_GAIN:      cfg_q.pos_gain      <= cfg_wdata_i;
        pdt_pkg::REG_VEL_GAIN:      cfg_q.vel_gain      <= cfg_wdata_i;
        pdt_pkg::REG_TORQUE_LIMIT:  cfg_q.torque_limit  <= cfg_wdata_i[14:0];
        pdt_pkg::REG_PD_ENABLE:     cfg_q.pd_enable     <= cfg_wdata_i[0];
        pdt_pkg::REG_STEP_LIMIT_ON: cfg_q.step_limit_on <= cfg_wdata_i[0];
        pdt_pkg::REG_STEP_LIMIT:    cfg_q.step_limit    <= cfg_wdata_i[14:0];
        pdt_pkg::REG_FILTER_ALPHA:  cfg_q.filter_alpha  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  pdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pdt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // magnitude checks on the delivered word
  logic [16:0] lim_p, lim_n, drv, drv_mag;
  assign lim_p   = {2'b00, cfg_q.torque_limit};
  assign lim_n   = 17'(-lim_p);
  assign drv     = 17'(out_data_o.drive_torque);
  assign drv_mag = drv[16] ? 17'(-drv) : drv;

  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "accepted word did not block input")
  `ASSERT_IMPL(a_clamp_at_limit, clk_i, rst_ni, out_valid_o && out_data_o.clamped, (drv == lim_p) || (drv == lim_n), "clamped word not at limit")
  `ASSERT_IMPL(a_below_limit, clk_i, rst_ni, out_valid_o && !out_data_o.clamped, drv_mag < lim_p, "unclamped word at or over limit")

endmodule
